>>> hw/rtl/cmm_pkg.sv
`default_nettype none

package cmm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int IDX_W       = 3;             // row / col field width
  localparam int DIM_W       = 4;             // dimension register width
  localparam int ADDR_FULL_W = 2 * IDX_W;     // row * MAX_DIM + col before trim
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int TERM_W      = PROD_W + 1;
  localparam int ACC_W       = 36;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    FN_WR_A = 2'd0,
    FN_WR_B = 2'd1,
    FN_MUL  = 2'd2
  } cmm_func_t;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_INNER  = 2'd1,
    REG_B_COLS = 2'd2
  } cmm_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WAIT
  } cmm_state_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd;
    logic             first;
    logic             last_k;
    logic             push;
    logic             last_elem;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmm_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } cmm_sts_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cmm_ram.sv
`default_nettype none

module cmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cmm_ctrl.sv
`default_nettype none

module cmm_ctrl #(
  parameter int MAX_DIM = cmm_pkg::MAX_DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire logic [1:0]                  func,
  input  wire logic [cmm_pkg::IDX_W-1:0]   row,
  input  wire logic [cmm_pkg::IDX_W-1:0]   col,
  input  wire logic [cmm_pkg::DIM_W-1:0]   a_rows,
  input  wire logic [cmm_pkg::DIM_W-1:0]   inner_size,
  input  wire logic [cmm_pkg::DIM_W-1:0]   b_cols,
  input  wire cmm_pkg::cmm_sts_t           sts,
  output cmm_pkg::cmm_cmd_t                cmd
);

  import cmm_pkg::*;

  localparam logic [DIM_W-1:0] MAXV = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] ONE  = {{(DIM_W-1){1'b0}}, 1'b1};

  cmm_state_t       state, state_next;
  logic [IDX_W-1:0] i, i_next, j, j_next, k, k_next;
  logic [DIM_W-1:0] nr, nk, nc;
  logic             in_range, i_end, j_end, k_end;

  assign nr = clamp_dim(a_rows, MAXV);
  assign nk = clamp_dim(inner_size, MAXV);
  assign nc = clamp_dim(b_cols, MAXV);

  assign in_range = ({1'b0, row} < MAXV) && ({1'b0, col} < MAXV);
  assign i_end    = ({1'b0, i} == nr - ONE);
  assign j_end    = ({1'b0, j} == nc - ONE);
  assign k_end    = ({1'b0, k} == nk - ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    item_ready    = 1'b0;
    cmd           = '0;
    cmd.i         = i;
    cmd.j         = j;
    cmd.k         = k;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          case (func)
            FN_WR_A: cmd.wr_a = in_range;
            FN_WR_B: cmd.wr_b = in_range;
            FN_MUL: begin
              state_next = ST_WALK;
              i_next     = '0;
              j_next     = '0;
              k_next     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.rd     = 1'b1;
        cmd.first  = (k == '0);
        cmd.last_k = k_end;
        if (k_end) begin
          k_next     = '0;
          state_next = ST_WAIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_WAIT: begin
        if (sts.acc_done && sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.last_elem = i_end && j_end;
          if (i_end && j_end) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_WALK;
            if (j_end) begin
              j_next = '0;
              i_next = i + 1'b1;
            end else begin
              j_next = j + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_walk_to_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && cmd.last_k) |=> (state == ST_WAIT))
    else $error("walk did not stop after the last inner index");

  a_final_push_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && cmd.last_elem) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the final result");

endmodule

`default_nettype wire

>>> hw/rtl/cmm_dp.sv
`default_nettype none

module cmm_dp #(
  parameter int MAX_DIM = cmm_pkg::MAX_DIM_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cmm_pkg::cmm_cmd_t                  cmd,
  output cmm_pkg::cmm_sts_t                       sts,
  input  wire logic        [cmm_pkg::IDX_W-1:0]   row,
  input  wire logic        [cmm_pkg::IDX_W-1:0]   col,
  input  wire logic signed [cmm_pkg::ELEM_W-1:0]  elem_re,
  input  wire logic signed [cmm_pkg::ELEM_W-1:0]  elem_im,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output logic             [cmm_pkg::IDX_W-1:0]   out_row,
  output logic             [cmm_pkg::IDX_W-1:0]   out_col,
  output logic signed      [cmm_pkg::ACC_W-1:0]   out_re,
  output logic signed      [cmm_pkg::ACC_W-1:0]   out_im,
  output logic                                    last
);

  import cmm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_FULL_W-1:0] STRIDE = ADDR_FULL_W'(MAX_DIM);
  localparam int EXT_W = ACC_W - TERM_W;

  logic [AW-1:0]         wr_addr, a_raddr, b_raddr;
  logic [PROD_W-1:0]     a_q, b_q;
  logic signed [ELEM_W-1:0] ar, ai, br, bi;

  logic s1_valid, s1_first, s1_last;
  logic s2_valid, s2_first, s2_last;
  logic s3_valid, s3_first, s3_last;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [TERM_W-1:0] t_re, t_im;
  logic signed [ACC_W-1:0]  acc_re, acc_im, ext_re, ext_im;
  logic                     acc_done;

  // element index = row * MAX_DIM + col
  assign wr_addr = AW'({{IDX_W{1'b0}}, row} * STRIDE + {{IDX_W{1'b0}}, col});
  assign a_raddr = AW'({{IDX_W{1'b0}}, cmd.i} * STRIDE + {{IDX_W{1'b0}}, cmd.k});
  assign b_raddr = AW'({{IDX_W{1'b0}}, cmd.k} * STRIDE + {{IDX_W{1'b0}}, cmd.j});

  cmm_ram #(.WIDTH(PROD_W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (wr_addr),
    .wdata ({elem_im, elem_re}),
    .re    (cmd.rd),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  cmm_ram #(.WIDTH(PROD_W), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (wr_addr),
    .wdata ({elem_im, elem_re}),
    .re    (cmd.rd),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  assign ar = a_q[ELEM_W-1:0];
  assign ai = a_q[PROD_W-1:ELEM_W];
  assign br = b_q[ELEM_W-1:0];
  assign bi = b_q[PROD_W-1:ELEM_W];

  assign ext_re = {{EXT_W{t_re[TERM_W-1]}}, t_re};
  assign ext_im = {{EXT_W{t_im[TERM_W-1]}}, t_im};

  // valid bits of the multiply-accumulate pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_valid <= cmd.rd;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (cmd.push) begin
        acc_done <= 1'b0;
      end else if (s3_valid && s3_last) begin
        acc_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.first;
    s1_last  <= cmd.last_k;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s3_first <= s2_first;
    s3_last  <= s2_last;
    p_rr     <= ar * br;
    p_ii     <= ai * bi;
    p_ri     <= ar * bi;
    p_ir     <= ai * br;
    t_re     <= {p_rr[PROD_W-1], p_rr} - {p_ii[PROD_W-1], p_ii};
    t_im     <= {p_ri[PROD_W-1], p_ri} + {p_ir[PROD_W-1], p_ir};
    if (s3_valid) begin
      acc_re <= s3_first ? ext_re : acc_re + ext_re;
      acc_im <= s3_first ? ext_im : acc_im + ext_im;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_row <= cmd.i;
      out_col <= cmd.j;
      out_re  <= acc_re;
      out_im  <= acc_im;
      last    <= cmd.last_elem;
    end
  end

  assign sts.acc_done = acc_done;
  assign sts.out_free = !result_valid || result_ready;

  a_push_needs_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> acc_done)
    else $error("result pushed before its sum was complete");

  a_pipe_empty_when_done: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> !(s1_valid || s2_valid || s3_valid || cmd.rd))
    else $error("products still in flight while a finished sum waits");

  a_no_write_during_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> !(cmd.wr_a || cmd.wr_b))
    else $error("element write during a product walk");

endmodule

`default_nettype wire

>>> hw/rtl/complex_matrix_multiply_unit.sv
// Channel  Direction  Signals                                     Transfer when
// -------  ---------  ------------------------------------------  ----------------------------
// item     in         item_valid/ready, func, row, col, elem_re/im  item_valid & item_ready
// result   out        result_valid/ready, out_row, out_col,        result_valid & result_ready
//                     out_re, out_im, last
// config   in         psel, penable, pwrite, paddr, pwdata, prdata  psel & penable & pwrite
//
// Element writes (A or B) follow back to back while no compute is running.
// A compute item walks C row by row: RAM reads across the inner dimension,
// then the multiply/accumulate pipe (products, terms, accumulator); each sum
// is pushed before the walk of the next element starts.
// A stalled result holds the walk before the next element starts; no new item
// is taken until the last result of a compute is in the result register.
// Reset (rst, synchronous, high) clears control and sets all dimensions to 8;
// the A and B stores hold nothing defined until written.
`default_nettype none

module complex_matrix_multiply_unit #(
  parameter int MAX_DIM = cmm_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // item channel
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic        [1:0]                 func,
  input  wire logic        [cmm_pkg::IDX_W-1:0]  row,
  input  wire logic        [cmm_pkg::IDX_W-1:0]  col,
  input  wire logic signed [cmm_pkg::ELEM_W-1:0] elem_re,
  input  wire logic signed [cmm_pkg::ELEM_W-1:0] elem_im,
  // result channel
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic             [cmm_pkg::IDX_W-1:0]  out_row,
  output logic             [cmm_pkg::IDX_W-1:0]  out_col,
  output logic signed      [cmm_pkg::ACC_W-1:0]  out_re,
  output logic signed      [cmm_pkg::ACC_W-1:0]  out_im,
  output logic                                   last,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic        [3:0]                 paddr,
  input  wire logic        [31:0]                pwdata,
  output logic             [31:0]                prdata,
  output logic                                   pready
);

  import cmm_pkg::*;

  logic [DIM_W-1:0] a_rows, inner_size, b_cols;
  logic             cfg_wr;
  cmm_cmd_t         cmd;
  cmm_sts_t         sts;

  // Register file: raw 4-bit values; clamping to 1..MAX_DIM is done at use.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows     <= DIM_RESET;
      inner_size <= DIM_RESET;
      b_cols     <= DIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_A_ROWS: a_rows     <= pwdata[DIM_W-1:0];
        REG_INNER:  inner_size <= pwdata[DIM_W-1:0];
        REG_B_COLS: b_cols     <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_A_ROWS: prdata = {{(32-DIM_W){1'b0}}, a_rows};
      REG_INNER:  prdata = {{(32-DIM_W){1'b0}}, inner_size};
      REG_B_COLS: prdata = {{(32-DIM_W){1'b0}}, b_cols};
      default:    prdata = '0;
    endcase
  end

  // Sequencer: decodes items, walks i/j/k, hands results to the output.
  cmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .func       (func),
    .row        (row),
    .col        (col),
    .a_rows     (a_rows),
    .inner_size (inner_size),
    .b_cols     (b_cols),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Stores, complex multiply-accumulate pipe and result register.
  cmm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .row          (row),
    .col          (col),
    .elem_re      (elem_re),
    .elem_im      (elem_im),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_re       (out_re),
    .out_im       (out_im),
    .last         (last)
  );

endmodule

`default_nettype wire

>>> tb/cmm_product_checker.sv
module cmm_product_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_ready,
  input  logic        [1:0]                 func,
  input  logic        [cmm_pkg::IDX_W-1:0]  row,
  input  logic        [cmm_pkg::IDX_W-1:0]  col,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_re,
  input  logic signed [cmm_pkg::ELEM_W-1:0] elem_im,
  input  logic                              result_valid,
  input  logic                              result_ready,
  input  logic        [cmm_pkg::IDX_W-1:0]  out_row,
  input  logic        [cmm_pkg::IDX_W-1:0]  out_col,
  input  logic signed [cmm_pkg::ACC_W-1:0]  out_re,
  input  logic signed [cmm_pkg::ACC_W-1:0]  out_im,
  input  logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic        [3:0]                 paddr,
  input  logic        [31:0]                pwdata,
  output int                                mismatches,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cmm_pkg::*;

  localparam int DIM = MAX_DIM_DEF;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic                    last;
  } product_elem_t;

  product_elem_t    expected_products[$];
  logic [31:0]      a_mat[DIM*DIM];   // {im, re}
  logic [31:0]      b_mat[DIM*DIM];
  logic [DIM_W-1:0] rows_reg;
  logic [DIM_W-1:0] inner_reg;
  logic [DIM_W-1:0] cols_reg;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int dim_of(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  task automatic note_mismatch(input string what, input logic [ACC_W-1:0] exp_v,
                               input logic [ACC_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected 'h%0h got 'h%0h", $realtime, what, exp_v, act_v);
  endtask

  // full C = A*B walk, row-major, exact sums
  task automatic multiply_out();
    int            nr, nk, nc;
    longint        sre, sim, ar, ai, br, bi;
    logic [31:0]   ea, eb;
    product_elem_t e;
    nr = dim_of(rows_reg);
    nk = dim_of(inner_reg);
    nc = dim_of(cols_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        sre = 0;
        sim = 0;
        for (int k = 0; k < nk; k++) begin
          ea = a_mat[i*DIM + k];
          eb = b_mat[k*DIM + j];
          ar = $signed(ea[15:0]);
          ai = $signed(ea[31:16]);
          br = $signed(eb[15:0]);
          bi = $signed(eb[31:16]);
          sre += ar * br - ai * bi;
          sim += ar * bi + ai * br;
        end
        e.row  = 3'(i);
        e.col  = 3'(j);
        e.re   = sre[ACC_W-1:0];
        e.im   = sim[ACC_W-1:0];
        e.last = (i == nr - 1) && (j == nc - 1);
        expected_products.push_back(e);
      end
    end
  endtask

  task automatic check_result();
    product_elem_t e;
    if (expected_products.size() == 0) begin
      note_mismatch("result with nothing pending", '0, out_re);
      return;
    end
    e = expected_products.pop_front();
    if (out_row !== e.row) note_mismatch("out_row", ACC_W'(e.row), ACC_W'(out_row));
    if (out_col !== e.col) note_mismatch("out_col", ACC_W'(e.col), ACC_W'(out_col));
    if (out_re !== e.re)   note_mismatch("out_re", e.re, out_re);
    if (out_im !== e.im)   note_mismatch("out_im", e.im, out_im);
    if (last !== e.last)   note_mismatch("last", ACC_W'(e.last), ACC_W'(last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      expected_products.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_A_ROWS: rows_reg  = pwdata[DIM_W-1:0];
          REG_INNER:  inner_reg = pwdata[DIM_W-1:0];
          REG_B_COLS: cols_reg  = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        case (func)
          FN_WR_A: a_mat[{row, col}] = {elem_im, elem_re};
          FN_WR_B: b_mat[{row, col}] = {elem_im, elem_re};
          FN_MUL:  multiply_out();
          default: ;
        endcase
      end
      if (result_valid && result_ready) check_result();
    end
    pending = expected_products.size();
  end

endmodule

>>> tb/tb_complex_matrix_multiply_unit.sv
module tb_complex_matrix_multiply_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cmm_pkg::*;

  // codes with no name in the package
  localparam logic [1:0] FN_UNUSED = 2'd3;   // ignored by the block
  localparam logic [1:0] REG_NONE  = 2'd3;   // address 12, no register there

  localparam int N_PHASES       = 6;
  localparam int PHASE_ITEMS    = 48;        // counted transfers per random phase
  localparam int IDLE_SETTLE    = 24;        // longer than an element's walk plus the pipe
  localparam int DRAIN_CYCLES   = 40;
  localparam int SINK_HOLD_LEN  = 400;       // long result back-pressure
  // all-compute worst case with longest gaps, on a 12 ns clock;
  // the limit sits well above that
  localparam longint LIMIT_NS   = 64'd100_000_000;

  logic                clk;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  logic [1:0]          func         = '0;
  logic [IDX_W-1:0]    row          = '0;
  logic [IDX_W-1:0]    col          = '0;
  logic signed [15:0]  elem_re      = '0;
  logic signed [15:0]  elem_im      = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [IDX_W-1:0]    out_row;
  logic [IDX_W-1:0]    out_col;
  logic signed [ACC_W-1:0] out_re;
  logic signed [ACC_W-1:0] out_im;
  logic                last;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [3:0]          paddr        = '0;
  logic [31:0]         pwdata       = '0;
  logic [31:0]         prdata;
  logic                pready;

  int   mismatches;
  int   pending;

  // idle knobs, in percent of transfers / cycles that open a gap
  int   src_idle_pct  = 30;
  int   sink_idle_pct = 30;
  logic sink_hold     = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  complex_matrix_multiply_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .row          (row),
    .col          (col),
    .elem_re      (elem_re),
    .elem_im      (elem_im),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_re       (out_re),
    .out_im       (out_im),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  cmm_product_checker product_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .row          (row),
    .col          (col),
    .elem_re      (elem_re),
    .elem_im      (elem_im),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_re       (out_re),
    .out_im       (out_im),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Gap length: mostly short, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Element value biased toward the Q1.15 corners.
  function automatic logic [15:0] rand_elem();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // One item transfer. Called at a falling edge; returns at a falling edge
  // with nothing assigned in that step, so the next call may raise valid.
  task automatic push_item(input logic [1:0] f, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [15:0] re,
                           input logic [15:0] im);
    item_valid <= 1'b1;
    func       <= f;
    row        <= r;
    col        <= c;
    elem_re    <= re;
    elem_im    <= im;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      item_valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  // APB write: setup, access, then a quiet step with psel low so back-to-back
  // calls never assign psel twice in one step. Upper data bits are junk.
  task automatic reg_write(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    logic [31:0] junk;
    junk    = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:DIM_W], val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle:
  // element writes and ignored items leave nothing to count on.
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  // Result sink: random ready with gaps; a hold request from the stimulus
  // side turns into one long stretch with ready low, counted here.
  initial begin : result_sink
    int len;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        result_ready <= 1'b0;
        repeat (SINK_HOLD_LEN - 1) @(negedge clk);
        sink_hold = 1'b0;
      end else if ($urandom_range(99) < sink_idle_pct) begin
        result_ready <= 1'b0;
        len = gap_len();
        repeat (len - 1) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int               sent;
    int               nr, nk, nc, nw, pick;
    logic [DIM_W-1:0] raw_rows, raw_inner, raw_cols;
    logic [IDX_W-1:0] r, c;
    logic             held;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill both stores completely so no compute ever reads an unwritten entry.
    // Row 0 of A and column 0 of B sit at the most negative value: with the
    // reset 8x8x8 shape, C[0][0] gets the largest possible imaginary sum.
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (i == 0) push_item(FN_WR_A, 3'(i), 3'(j), 16'h8000, 16'h8000);
        else        push_item(FN_WR_A, 3'(i), 3'(j), rand_elem(), rand_elem());
      end
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (j == 0) push_item(FN_WR_B, 3'(i), 3'(j), 16'h8000, 16'h8000);
        else        push_item(FN_WR_B, 3'(i), 3'(j), rand_elem(), rand_elem());
      end
    end

    // Directed part.
    // Compute at reset dimensions; row/col carry junk that must be ignored.
    push_item(FN_MUL, 3'd7, 3'd7, 16'hFFFF, 16'h8000);
    // Unused func code: no result, no store change.
    push_item(FN_UNUSED, 3'd5, 3'd2, 16'h1234, 16'h8765);
    wait_idle();

    // 1x1x1 with corner operands.
    reg_write(REG_A_ROWS, 4'd1);
    reg_write(REG_INNER, 4'd1);
    reg_write(REG_B_COLS, 4'd1);
    push_item(FN_WR_A, 3'd0, 3'd0, 16'h8000, 16'h8000);
    push_item(FN_WR_B, 3'd0, 3'd0, 16'h8000, 16'h7FFF);
    push_item(FN_MUL, 3'd0, 3'd0, 16'h0000, 16'h0000);
    push_item(FN_WR_A, 3'd0, 3'd0, 16'h7FFF, 16'h7FFF);
    push_item(FN_WR_B, 3'd0, 3'd0, 16'h7FFF, 16'h8000);
    push_item(FN_MUL, 3'd2, 3'd6, 16'h7FFF, 16'h7FFF);
    wait_idle();

    // Zero dimension acts as 1, above-maximum saturates to 8, and a write to
    // the empty address leaves everything alone: shape becomes 1x8 by 8x8.
    reg_write(REG_A_ROWS, 4'd0);
    reg_write(REG_INNER, 4'hF);
    reg_write(REG_B_COLS, 4'd9);
    reg_write(REG_NONE, 4'd2);
    push_item(FN_MUL, 3'd1, 3'd1, 16'h0000, 16'hFFFF);
    wait_idle();

    // Random phases, each at its own shape and idle mix.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin raw_rows = 4'd1; raw_inner = 4'd1; raw_cols = 4'd1; end
        1: begin raw_rows = 4'd8; raw_inner = 4'd8; raw_cols = 4'd8; end
        2: begin raw_rows = 4'd0; raw_inner = 4'hF; raw_cols = 4'd0; end
        default: begin
          raw_rows  = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(1, 3));
          raw_inner = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(1, 3));
          raw_cols  = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(1, 3));
        end
      endcase
      reg_write(REG_A_ROWS, raw_rows);
      reg_write(REG_INNER, raw_inner);
      reg_write(REG_B_COLS, raw_cols);
      nr = (raw_rows == 0) ? 1 : (raw_rows > 8) ? 8 : int'(raw_rows);
      nk = (raw_inner == 0) ? 1 : (raw_inner > 8) ? 8 : int'(raw_inner);
      nc = (raw_cols == 0) ? 1 : (raw_cols > 8) ? 8 : int'(raw_cols);

      // every third phase runs with no idling on either side
      if (ph % 3 == 0) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = $urandom_range(10, 50);
        sink_idle_pct = $urandom_range(10, 50);
      end

      sent = 0;
      held = 1'b0;
      while (sent < PHASE_ITEMS) begin
        // Burst of element loads, mostly inside the active shape, then compute.
        nw = $urandom_range(1, 12);
        for (int w = 0; w < nw; w++) begin
          pick = $urandom_range(99);
          if (pick < 5) begin
            push_item(FN_UNUSED, 3'($urandom()), 3'($urandom()), rand_elem(), rand_elem());
          end else if (pick < 85) begin
            if ($urandom_range(1) == 0) begin
              r = 3'($urandom_range(nr - 1));
              c = 3'($urandom_range(nk - 1));
              push_item(FN_WR_A, r, c, rand_elem(), rand_elem());
            end else begin
              r = 3'($urandom_range(nk - 1));
              c = 3'($urandom_range(nc - 1));
              push_item(FN_WR_B, r, c, rand_elem(), rand_elem());
            end
            sent++;
          end else begin
            push_item(($urandom_range(1) == 0) ? FN_WR_A : FN_WR_B,
                      3'($urandom()), 3'($urandom()), rand_elem(), rand_elem());
            sent++;
          end
        end
        // On the full-size phase the sink stalls for a long stretch during
        // the first compute while loads keep coming, so the input backs up.
        if (ph == 1 && !held) begin
          sink_hold = 1'b1;
          held      = 1'b1;
        end
        push_item(FN_MUL, 3'($urandom()), 3'($urandom()), rand_elem(), rand_elem());
        sent++;
      end
      wait_idle();
    end

    // All transfers in: drain, then a few more cycles for stray results.
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
